// ----- rtl/core/lpms_pkg.sv -----
// ----------------------------------------------------------------------------
// lpms_pkg: shared types, constants and sizing functions
// Field widths, request kinds, sequencer states and histogram commands used
// by the label propagation round engine.
// ----------------------------------------------------------------------------
package lpms_pkg;

  // Default node count and fixed field widths.
  localparam int NODES_DEF = 1024;
  localparam int NODE_W    = 10;
  localparam int LABEL_W   = 11;
  localparam int COUNT_W   = 11;
  localparam int NODE_SPAN = 1 << NODE_W;
  localparam int LABEL_TOP = (1 << LABEL_W) - 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Request kinds. The fourth code is ignored by the engine.
  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_COUNT = 2'd1,
    KIND_SWAP  = 2'd2
  } kind_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_RED,
    ST_EXEC,
    ST_LBL,
    ST_CNT,
    ST_OLD,
    ST_CLR_RD,
    ST_CLR_WR
  } state_t;

  // Commands to the histogram unit.
  typedef enum logic [2:0] {
    HOP_NONE,
    HOP_INIT,
    HOP_READ,
    HOP_COUNT,
    HOP_CLR_RD,
    HOP_CLR_WR
  } hist_op_t;

  // Status returned by the histogram unit.
  typedef struct packed {
    logic init_last;
    logic clr_last;
  } hist_sts_t;

  // Number of label bank entries that a node index can reach.
  function automatic int bank_depth(int nodes);
    return (nodes < NODE_SPAN) ? nodes : NODE_SPAN;
  endfunction

  // Largest label that can be stored after saturation.
  function automatic int label_max(int nodes);
    return (nodes < LABEL_TOP) ? nodes : LABEL_TOP;
  endfunction

  // Conditional subtract steps needed to reduce a node field modulo nodes.
  function automatic int reduce_steps(int nodes);
    int steps;
    steps = 0;
    for (int k = 0; k < NODE_W; k++) begin
      if ((nodes << k) < NODE_SPAN) steps = k + 1;
    end
    return steps;
  endfunction

endpackage

// ----- rtl/core/lpms_banks.sv -----
// ----------------------------------------------------------------------------
// lpms_banks: label bank memory
// Both label banks in one single-port-write, single-port-read memory; the
// bank select forms the top address bit. Read data is registered.
// ----------------------------------------------------------------------------
module lpms_banks import lpms_pkg::*; #(
  parameter int ADDR_W = NODE_W + 1
) (
  input  logic               clk,
  input  logic               rd_en,
  input  logic [ADDR_W-1:0]  rd_addr,
  output logic [LABEL_W-1:0] rd_data,
  input  logic               wr_en,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  logic [LABEL_W-1:0] wr_data
);

  localparam int WORDS = 1 << ADDR_W;

  logic [LABEL_W-1:0] mem [WORDS];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/core/lpms_hist.sv -----
// ----------------------------------------------------------------------------
// lpms_hist: label histogram for one group
// Count memory with a read-modify-write path, the list of touched labels,
// the running winner, the clearing sweep after reset and the clearing walk
// over the touched list at the end of a group.
// ----------------------------------------------------------------------------
module lpms_hist import lpms_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  hist_op_t           op,
  input  logic [LABEL_W-1:0] label,
  output hist_sts_t          sts,
  output logic [LABEL_W-1:0] best_label
);

  localparam int LBL_MAX   = label_max(NODES);
  localparam int CNT_DEPTH = LBL_MAX + 1;
  localparam int CNT_AW    = $clog2(CNT_DEPTH);
  localparam int TT_W      = $clog2(CNT_DEPTH + 1);

  logic [COUNT_W-1:0] count_mem   [CNT_DEPTH];
  logic [CNT_AW-1:0]  touched_mem [CNT_DEPTH];

  logic [COUNT_W-1:0] cnt_rd_r;
  logic [CNT_AW-1:0]  lbl_r;
  logic [CNT_AW-1:0]  clr_lbl_r;
  logic [CNT_AW-1:0]  init_idx_r, init_idx_nxt;
  logic [TT_W-1:0]    touched_total_r, touched_total_nxt;
  logic [TT_W-1:0]    clr_idx_r, clr_idx_nxt;
  logic [LABEL_W-1:0] best_label_r, best_label_nxt;
  logic [COUNT_W-1:0] best_count_r, best_count_nxt;

  logic [COUNT_W-1:0] cnt_inc;
  logic               better;
  logic               cnt_we;
  logic [CNT_AW-1:0]  cnt_wa;
  logic [COUNT_W-1:0] cnt_wd;
  logic               tl_we;

  // Saturating increment and the winner test: higher count, or the smaller
  // label on an equal count.
  assign cnt_inc = (cnt_rd_r == COUNT_MAX) ? cnt_rd_r : cnt_rd_r + COUNT_W'(1);
  assign better  = (cnt_inc > best_count_r) ||
                   ((cnt_inc == best_count_r) && (LABEL_W'(lbl_r) < best_label_r));

  assign sts.init_last = (init_idx_r == CNT_AW'(CNT_DEPTH - 1));
  assign sts.clr_last  = ((clr_idx_r + TT_W'(1)) == touched_total_r);
  assign best_label    = best_label_r;

  // Command decoder and next-state logic.
  always_comb begin
    init_idx_nxt      = init_idx_r;
    touched_total_nxt = touched_total_r;
    clr_idx_nxt       = clr_idx_r;
    best_label_nxt    = best_label_r;
    best_count_nxt    = best_count_r;
    cnt_we            = 1'b0;
    cnt_wa            = lbl_r;
    cnt_wd            = cnt_inc;
    tl_we             = 1'b0;
    unique case (op)
      HOP_INIT: begin
        cnt_we       = 1'b1;
        cnt_wa       = init_idx_r;
        cnt_wd       = '0;
        init_idx_nxt = init_idx_r + CNT_AW'(1);
      end
      HOP_COUNT: begin
        cnt_we = 1'b1;
        if (cnt_rd_r == '0) begin
          tl_we             = 1'b1;
          touched_total_nxt = touched_total_r + TT_W'(1);
        end
        if (better) begin
          best_label_nxt = LABEL_W'(lbl_r);
          best_count_nxt = cnt_inc;
        end
      end
      HOP_CLR_WR: begin
        cnt_we = 1'b1;
        cnt_wa = clr_lbl_r;
        cnt_wd = '0;
        if (sts.clr_last) begin
          clr_idx_nxt       = '0;
          touched_total_nxt = '0;
          best_label_nxt    = '0;
          best_count_nxt    = '0;
        end else begin
          clr_idx_nxt = clr_idx_r + TT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_idx_r      <= '0;
      touched_total_r <= '0;
      clr_idx_r       <= '0;
      best_label_r    <= '0;
      best_count_r    <= '0;
    end else begin
      init_idx_r      <= init_idx_nxt;
      touched_total_r <= touched_total_nxt;
      clr_idx_r       <= clr_idx_nxt;
      best_label_r    <= best_label_nxt;
      best_count_r    <= best_count_nxt;
    end
  end

  // Count memory: one write port, registered read.
  always_ff @(posedge clk) begin
    if (cnt_we) count_mem[cnt_wa] <= cnt_wd;
    if (op == HOP_READ) begin
      cnt_rd_r <= count_mem[label[CNT_AW-1:0]];
      lbl_r    <= label[CNT_AW-1:0];
    end
  end

  // Touched label list: appended on a first count, read back when clearing.
  always_ff @(posedge clk) begin
    if (tl_we) touched_mem[touched_total_r[CNT_AW-1:0]] <= lbl_r;
    if (op == HOP_CLR_RD) clr_lbl_r <= touched_mem[clr_idx_r[CNT_AW-1:0]];
  end

  // A non-empty group always has a winner with a count of at least one.
  assert property (@(posedge clk) disable iff (!rst_n)
    (touched_total_r != '0) |-> (best_count_r != '0))
    else $error("histogram has touched labels but no winner count");

  // The last clearing write leaves the histogram empty.
  assert property (@(posedge clk) disable iff (!rst_n)
    (op == HOP_CLR_WR && sts.clr_last) |=> (touched_total_r == '0 && best_count_r == '0))
    else $error("histogram not empty after the clearing walk");

endmodule

// ----- rtl/core/label_propagation_mode_select.sv -----
// ----------------------------------------------------------------------------
// label_propagation_mode_select: synchronous label propagation round engine
// Loads labels, counts group members into a histogram, reports the most
// frequent label for each target and swaps the two label banks per round.
// ----------------------------------------------------------------------------
// After reset the block sweeps its count memory to zero, one entry a cycle
// over NODES+1 entries (1025 at the default, capped at 2048), and takes no
// request until that is done. A load or bank swap request ends in the execute
// step; a member count request goes on to the label bank read followed by the
// count memory read-modify-write. The last member of a group then does the old
// label read and bank write, waiting while the previous result is still not
// taken, and clears the touched count of each distinct label counted in the
// group. For NODES below 1024 every request first passes the conditional
// subtract steps of the node index reduction (ceil(log2(1024/NODES)) steps).
// ----------------------------------------------------------------------------
module label_propagation_mode_select import lpms_pkg::*; #(
  parameter int NODES = NODES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic [NODE_W-1:0]  in_member_node,
  input  logic [NODE_W-1:0]  in_target_node,
  input  logic [LABEL_W-1:0] in_initial_label,
  input  logic               in_last_member,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [NODE_W-1:0]  out_relabeled_node,
  output logic [LABEL_W-1:0] out_new_label,
  output logic               out_changed
);

  localparam int BANK_DEPTH = bank_depth(NODES);
  localparam int NODE_AW    = $clog2(BANK_DEPTH);
  localparam int BANK_AW    = NODE_AW + 1;
  localparam int LBL_MAX    = label_max(NODES);
  localparam int RED_STEPS  = reduce_steps(NODES);
  localparam int RED_CW     = (RED_STEPS > 0) ? $clog2(RED_STEPS + 1) : 1;
  localparam int DIV_START  = (RED_STEPS > 0) ? (NODES << (RED_STEPS - 1)) : 0;

  localparam logic [LABEL_W-1:0] LABEL_SAT = LABEL_W'(LBL_MAX);

  state_t              state_r, state_nxt;
  logic [1:0]          kind_r;
  logic [LABEL_W-1:0]  init_r;
  logic                last_r;
  logic [NODE_W-1:0]   member_r, member_nxt;
  logic [NODE_W-1:0]   target_r, target_nxt;
  logic [NODE_W-1:0]   div_r, div_nxt;
  logic [RED_CW-1:0]   step_r, step_nxt;
  logic                bank_sel_r, bank_sel_nxt;

  logic                out_valid_r;
  logic [NODE_W-1:0]   out_node_r;
  logic [LABEL_W-1:0]  out_label_r;
  logic                out_changed_r;
  logic                out_load;
  logic                out_free;

  logic                bk_re, bk_we;
  logic [BANK_AW-1:0]  bk_ra, bk_wa;
  logic [LABEL_W-1:0]  bk_wd, bk_rdata;

  hist_op_t            hop;
  hist_sts_t           hsts;
  logic [LABEL_W-1:0]  best_label;

  logic [LABEL_W-1:0]  label_sat;
  logic [NODE_AW-1:0]  member_idx, target_idx;

  assign label_sat  = (init_r > LABEL_SAT) ? LABEL_SAT : init_r;
  assign member_idx = member_r[NODE_AW-1:0];
  assign target_idx = target_r[NODE_AW-1:0];
  assign out_free   = !out_valid_r || out_ready;

  // Label banks.
  lpms_banks #(
    .ADDR_W (BANK_AW)
  ) u_banks (
    .clk     (clk),
    .rd_en   (bk_re),
    .rd_addr (bk_ra),
    .rd_data (bk_rdata),
    .wr_en   (bk_we),
    .wr_addr (bk_wa),
    .wr_data (bk_wd)
  );

  // Histogram of the open group.
  lpms_hist #(
    .NODES (NODES)
  ) u_hist (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (hop),
    .label      (bk_rdata),
    .sts        (hsts),
    .best_label (best_label)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_INIT;
      bank_sel_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      bank_sel_r <= bank_sel_nxt;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    member_r <= member_nxt;
    target_r <= target_nxt;
    div_r    <= div_nxt;
    step_r   <= step_nxt;
    if (in_valid && in_ready) begin
      kind_r <= in_kind;
      init_r <= in_initial_label;
      last_r <= in_last_member;
    end
  end

  // Next state, reduction unit, bank and histogram control.
  always_comb begin
    state_nxt    = state_r;
    member_nxt   = member_r;
    target_nxt   = target_r;
    div_nxt      = div_r;
    step_nxt     = step_r;
    bank_sel_nxt = bank_sel_r;
    bk_re        = 1'b0;
    bk_ra        = {bank_sel_r, member_idx};
    bk_we        = 1'b0;
    bk_wa        = {bank_sel_r, member_idx};
    bk_wd        = label_sat;
    hop          = HOP_NONE;
    in_ready     = 1'b0;
    out_load     = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        hop = HOP_INIT;
        if (hsts.init_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          member_nxt = in_member_node;
          target_nxt = in_target_node;
          div_nxt    = NODE_W'(DIV_START);
          step_nxt   = '0;
          state_nxt  = (RED_STEPS > 0) ? ST_RED : ST_EXEC;
        end
      end
      ST_RED: begin
        // One conditional subtract of a shifted node count per cycle.
        if (member_r >= div_r) member_nxt = member_r - div_r;
        if (target_r >= div_r) target_nxt = target_r - div_r;
        div_nxt  = div_r >> 1;
        step_nxt = step_r + RED_CW'(1);
        if (step_r == RED_CW'(RED_STEPS - 1)) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
        unique case (kind_r)
          KIND_LOAD: bk_we = 1'b1;
          KIND_SWAP: bank_sel_nxt = !bank_sel_r;
          KIND_COUNT: begin
            bk_re     = 1'b1;
            state_nxt = ST_LBL;
          end
          default: begin
          end
        endcase
      end
      ST_LBL: begin
        hop       = HOP_READ;
        state_nxt = ST_CNT;
      end
      ST_CNT: begin
        hop = HOP_COUNT;
        if (last_r) begin
          bk_re     = 1'b1;
          bk_ra     = {bank_sel_r, target_idx};
          state_nxt = ST_OLD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OLD: begin
        // Hold the old label read until the result register is free.
        bk_re = 1'b1;
        bk_ra = {bank_sel_r, target_idx};
        if (out_free) begin
          bk_we     = 1'b1;
          bk_wa     = {!bank_sel_r, target_idx};
          bk_wd     = best_label;
          out_load  = 1'b1;
          state_nxt = ST_CLR_RD;
        end
      end
      ST_CLR_RD: begin
        hop       = HOP_CLR_RD;
        state_nxt = ST_CLR_WR;
      end
      ST_CLR_WR: begin
        hop       = HOP_CLR_WR;
        state_nxt = hsts.clr_last ? ST_IDLE : ST_CLR_RD;
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_node_r    <= target_r;
      out_label_r   <= best_label;
      out_changed_r <= (best_label != bk_rdata);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_relabeled_node = out_node_r;
  assign out_new_label      = out_label_r;
  assign out_changed        = out_changed_r;

  // A result request only appears after the old label has been read.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_OLD))
    else $error("result raised outside the group end step");

  // A swap request flips the bank select exactly once.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && kind_r == KIND_SWAP) |=> (bank_sel_r != $past(bank_sel_r)))
    else $error("bank select did not flip on a swap request");

  // Node indices are fully reduced before any bank access.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |->
      ({1'b0, member_r} < (NODE_W + 1)'(BANK_DEPTH) &&
       {1'b0, target_r} < (NODE_W + 1)'(BANK_DEPTH)))
    else $error("node index not reduced below the node count");

endmodule

// ----- test/label_propagation_mode_select_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// label_propagation_mode_select_tb: self-checking testbench for the round engine
// Sends label loads, group member counts and bank swaps over a valid/ready
// channel. A scoreboard keeps its own copy of both label banks and of the
// histogram, and it predicts each relabel result. The run starts with directed
// requests for ties, saturating labels and groups that are interrupted by
// loads and swaps. Random rounds of loads and groups follow, with random
// idling on both channels and one long hold-off on the output.
// ----------------------------------------------------------------------------
module label_propagation_mode_select_tb;
  import lpms_pkg::*;

  localparam logic [1:0]         KIND_UNUSED  = 2'd3;
  localparam logic [LABEL_W-1:0] LABEL_SAT    = LABEL_W'(NODES_DEF);
  localparam int                 RAND_ITEMS   = 360;
  localparam int                 PRESS_CYCLES = 400;
  localparam int                 IDLE_LIMIT   = 20000;

  typedef struct packed {
    logic [NODE_W-1:0]  node;
    logic [LABEL_W-1:0] label;
    logic               changed;
  } relabel_t;

  // Scoreboard: predicts relabel results from the accepted requests.
  class label_round_scoreboard;
    logic [LABEL_W-1:0] bank [2*NODE_SPAN];
    bit                 cur_sel;
    logic [COUNT_W-1:0] hist [NODES_DEF+1];
    int                 touched[$];
    logic [LABEL_W-1:0] best_lbl;
    logic [COUNT_W-1:0] best_cnt;
    relabel_t           pending_q[$];
    int                 errors;
    int                 results_seen;

    function new();
      foreach (hist[i]) hist[i] = '0;
      cur_sel      = 1'b0;
      best_lbl     = '0;
      best_cnt     = '0;
      errors       = 0;
      results_seen = 0;
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    // Apply one accepted request to the copy of the state.
    function void note_request(logic [1:0] kind, logic [NODE_W-1:0] member,
                               logic [NODE_W-1:0] target, logic [LABEL_W-1:0] lbl_in,
                               logic last);
      logic [LABEL_W-1:0] lbl;
      logic [LABEL_W-1:0] old_lbl;
      logic [COUNT_W-1:0] cnt;
      relabel_t           exp_r;
      case (kind)
        KIND_LOAD: begin
          lbl = (lbl_in > LABEL_SAT) ? LABEL_SAT : lbl_in;
          bank[{cur_sel, member}] = lbl;
        end
        KIND_SWAP: begin
          cur_sel = ~cur_sel;
        end
        KIND_COUNT: begin
          // Histogram update and running winner, smaller label on ties.
          lbl = bank[{cur_sel, member}];
          cnt = hist[lbl];
          if (cnt == '0) touched.insert(touched.size(), int'(lbl));
          if (cnt != COUNT_MAX) cnt = cnt + 1'b1;
          hist[lbl] = cnt;
          if (cnt > best_cnt || (cnt == best_cnt && lbl < best_lbl)) begin
            best_cnt = cnt;
            best_lbl = lbl;
          end
          // The last member writes the winner to the other bank and clears.
          if (last) begin
            old_lbl = bank[{cur_sel, target}];
            bank[{~cur_sel, target}] = best_lbl;
            exp_r.node    = target;
            exp_r.label   = best_lbl;
            exp_r.changed = (best_lbl != old_lbl);
            pending_q.insert(pending_q.size(), exp_r);
            foreach (touched[i]) hist[touched[i]] = '0;
            touched.delete();
            best_lbl = '0;
            best_cnt = '0;
          end
        end
        default: begin
        end
      endcase
    endfunction

    // Compare one accepted result with the oldest expectation.
    task check_result(logic [NODE_W-1:0] node, logic [LABEL_W-1:0] label, logic changed);
      relabel_t e;
      results_seen++;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result node %0d label %0d changed %0b",
                                  node, label, changed));
        return;
      end
      e = pending_q.pop_front();
      if (node !== e.node)
        report_mismatch($sformatf("relabeled_node %0d, expected %0d", node, e.node));
      if (label !== e.label)
        report_mismatch($sformatf("new_label %0d, expected %0d (node %0d)",
                                  label, e.label, e.node));
      if (changed !== e.changed)
        report_mismatch($sformatf("changed %0b, expected %0b (node %0d)",
                                  changed, e.changed, e.node));
    endtask

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_kind = KIND_LOAD;
  logic [NODE_W-1:0]  in_member_node = '0;
  logic [NODE_W-1:0]  in_target_node = '0;
  logic [LABEL_W-1:0] in_initial_label = '0;
  logic               in_last_member = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [NODE_W-1:0]  out_relabeled_node;
  logic [LABEL_W-1:0] out_new_label;
  logic               out_changed;

  label_round_scoreboard relabel_sb = new();

  // Generator view of which bank entries have been written.
  bit written [2*NODE_SPAN];
  int live_a[$];
  int live_b[$];
  bit gen_sel = 1'b0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int n_load, n_count, n_swap, n_ignored;
  int idle_cycles = 0;
  int rx_stall = 0;
  int press_left = 0;
  bit press_done = 1'b0;

  label_propagation_mode_select dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_member_node     (in_member_node),
    .in_target_node     (in_target_node),
    .in_initial_label   (in_initial_label),
    .in_last_member     (in_last_member),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_relabeled_node (out_relabeled_node),
    .out_new_label      (out_new_label),
    .out_changed        (out_changed)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Idle lengths: mostly short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int tx_gap();
    if (tx_calm || $urandom_range(0, 99) < 50) return 0;
    return gap_len();
  endfunction

  // Labels: a small palette for ties, plus zero, saturating and full range.
  function automatic logic [LABEL_W-1:0] rand_label();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return LABEL_W'($urandom_range(1, 6));
    if (r < 75) return LABEL_W'($urandom_range(0, LABEL_TOP));
    if (r < 85) return '0;
    if (r < 95) return LABEL_W'($urandom_range(NODES_DEF, LABEL_TOP));
    return LABEL_W'($urandom_range(1, NODES_DEF));
  endfunction

  function automatic logic [NODE_W-1:0] rand_node();
    return NODE_W'($urandom_range(0, NODE_SPAN - 1));
  endfunction

  function automatic void mark_written(logic [NODE_W:0] idx);
    if (!written[idx]) begin
      written[idx] = 1'b1;
      if (idx[NODE_W]) live_b.insert(live_b.size(), int'(idx[NODE_W-1:0]));
      else live_a.insert(live_a.size(), int'(idx[NODE_W-1:0]));
    end
  endfunction

  function automatic int live_count();
    return gen_sel ? live_b.size() : live_a.size();
  endfunction

  function automatic logic [NODE_W-1:0] pick_live();
    if (gen_sel) return NODE_W'(live_b[$urandom_range(0, live_b.size() - 1)]);
    return NODE_W'(live_a[$urandom_range(0, live_a.size() - 1)]);
  endfunction

  // Offer one request, wait for it to be taken, then sometimes idle for a while.
  task automatic send_request(logic [1:0] kind, logic [NODE_W-1:0] member,
                              logic [NODE_W-1:0] target, logic [LABEL_W-1:0] lbl,
                              logic last);
    int gap;
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_member_node   <= member;
    in_target_node   <= target;
    in_initial_label <= lbl;
    in_last_member   <= last;
    do @(posedge clk); while (!in_ready);
    relabel_sb.note_request(kind, member, target, lbl, last);
    case (kind)
      KIND_LOAD: begin
        mark_written({gen_sel, member});
        n_load++;
      end
      KIND_SWAP: begin
        gen_sel = ~gen_sel;
        n_swap++;
      end
      KIND_COUNT: begin
        if (last) mark_written({~gen_sel, target});
        n_count++;
      end
      default: n_ignored++;
    endcase
    gap = tx_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_random();
    send_request(KIND_LOAD, rand_node(), rand_node(), rand_label(),
                 1'($urandom_range(0, 1)));
  endtask

  task automatic member_request(logic [NODE_W-1:0] member, logic [NODE_W-1:0] target,
                                logic last);
    send_request(KIND_COUNT, member, target, LABEL_W'($urandom_range(0, LABEL_TOP)), last);
  endtask

  task automatic swap_request();
    send_request(KIND_SWAP, rand_node(), rand_node(),
                 LABEL_W'($urandom_range(0, LABEL_TOP)), 1'($urandom_range(0, 1)));
  endtask

  task automatic unused_request();
    send_request(KIND_UNUSED, rand_node(), rand_node(),
                 LABEL_W'($urandom_range(0, LABEL_TOP)), 1'($urandom_range(0, 1)));
  endtask

  // One group: members from written nodes, with the odd load, swap or
  // ignored request mixed in before the last member.
  task automatic random_group();
    int                size;
    int                r;
    logic [NODE_W-1:0] target;
    logic [NODE_W-1:0] member;
    logic [NODE_W-1:0] tgt_field;
    size   = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 24);
    target = pick_live();
    for (int i = 0; i < size; i++) begin
      r = $urandom_range(0, 99);
      if (r < 5) load_random();
      else if (r < 8) unused_request();
      else if (r < 10) swap_request();
      if (live_count() == 0) load_random();
      member = (i == 0 && written[{gen_sel, target}]) ? target : pick_live();
      if (i == size - 1) begin
        if (!written[{gen_sel, target}]) target = pick_live();
        member_request(member, target, 1'b1);
      end else begin
        tgt_field = ($urandom_range(0, 1) != 0) ? target : rand_node();
        member_request(member, tgt_field, 1'b0);
      end
    end
  endtask

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      relabel_sb.check_result(out_relabeled_node, out_new_label, out_changed);
  end

  // Receiver: random stalls, calm stretches and one long hold-off.
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) rx_calm <= ~rx_calm;
    if (press_left > 0) begin
      out_ready  <= 1'b0;
      press_left <= press_left - 1;
    end else if (!press_done && relabel_sb.results_seen >= 30) begin
      out_ready  <= 1'b0;
      press_left <= PRESS_CYCLES;
      press_done <= 1'b1;
    end else if (rx_stall > 0) begin
      out_ready <= 1'b0;
      rx_stall  <= rx_stall - 1;
    end else begin
      out_ready <= 1'b1;
      if (!rx_calm && $urandom_range(0, 99) < 25) rx_stall <= gap_len();
    end
  end

  // Watchdog: ends the run after too long without any handshake.
  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("label_propagation_mode_select_tb failed");
    $finish;
  end

  // Main sequence.
  initial begin
    int rand_items;
    int r;
    int burst;
    int n_base;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extreme nodes, zero and saturating labels.
    send_request(KIND_LOAD, 10'd0, 10'd1023, 11'd1, 1'b1);
    send_request(KIND_LOAD, 10'd1023, 10'd0, 11'd1024, 1'b0);
    send_request(KIND_LOAD, 10'd5, 10'd1023, 11'd2047, 1'b1);
    send_request(KIND_LOAD, 10'd6, 10'd0, 11'd0, 1'b0);
    send_request(KIND_LOAD, 10'd7, 10'd1023, 11'd1025, 1'b1);
    send_request(KIND_LOAD, 10'd8, 10'd0, 11'd3, 1'b0);
    // Clear winner, then a tie that goes to label zero.
    member_request(10'd0, 10'd0, 1'b0);
    member_request(10'd1023, 10'd0, 1'b0);
    member_request(10'd5, 10'd0, 1'b1);
    member_request(10'd6, 10'd6, 1'b0);
    member_request(10'd8, 10'd6, 1'b1);
    // The unused kind is ignored.
    send_request(KIND_UNUSED, 10'd1023, 10'd1023, 11'd2047, 1'b1);
    // Only the target of the last member counts.
    member_request(10'd0, 10'd17, 1'b0);
    member_request(10'd8, 10'd999, 1'b0);
    member_request(10'd1023, 10'd1023, 1'b1);
    // A load inside an open group.
    member_request(10'd8, 10'd8, 1'b0);
    send_request(KIND_LOAD, 10'd8, 10'd8, 11'd2, 1'b1);
    member_request(10'd8, 10'd8, 1'b1);
    // A swap inside an open group, then back to the first bank.
    member_request(10'd7, 10'd7, 1'b0);
    member_request(10'd0, 10'd7, 1'b0);
    swap_request();
    member_request(10'd0, 10'd0, 1'b1);
    swap_request();

    // Random rounds: load bursts, groups, swaps and ignored requests.
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      n_base = n_load + n_count + n_swap;
      if ($urandom_range(0, 29) == 0) tx_calm = ~tx_calm;
      r = $urandom_range(0, 99);
      if (live_count() < 3 || r < 15) begin
        burst = $urandom_range(1, 5);
        repeat (burst) load_random();
      end else if (r < 85) begin
        random_group();
      end else if (r < 93) begin
        swap_request();
      end else begin
        unused_request();
      end
      rand_items += n_load + n_count + n_swap - n_base;
    end
    in_valid <= 1'b0;

    // Drain, then let the block settle.
    while (relabel_sb.pending() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (relabel_sb.pending() != 0)
      relabel_sb.report_mismatch("expected results left over at the end");

    $display("Run covered %0d loads, %0d member counts, %0d swaps and %0d ignored requests.",
             n_load, n_count, n_swap, n_ignored);
    $display("Checked %0d relabel results, including label ties and a long output hold.",
             relabel_sb.results_seen);
    if (relabel_sb.errors == 0) begin
      $display("label_propagation_mode_select_tb passed");
    end else begin
      $display("label_propagation_mode_select_tb failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/lpms_pkg.sv
rtl/core/lpms_banks.sv
rtl/core/lpms_hist.sv
rtl/core/label_propagation_mode_select.sv
test/label_propagation_mode_select_tb.sv
